>>> rtl/core/rme_pkg.sv
// Shared types and codes for the register machine execute unit.
// Depends on nothing; every module of the unit imports it.
`default_nettype none

package rme_pkg;

  // Instruction kinds
  localparam logic [3:0] KIND_START    = 4'd0;
  localparam logic [3:0] KIND_EXIT     = 4'd1;
  localparam logic [3:0] KIND_ADD      = 4'd2;
  localparam logic [3:0] KIND_SUB      = 4'd3;
  localparam logic [3:0] KIND_SHOW     = 4'd4;
  localparam logic [3:0] KIND_MOVE_REG = 4'd5;
  localparam logic [3:0] KIND_MOVE_IMM = 4'd6;
  localparam logic [3:0] KIND_LOAD     = 4'd7;
  localparam logic [3:0] KIND_STORE    = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_HALT     = 2'd3;

  // Register file geometry
  localparam int         NUM_REGS = 7;
  localparam logic [2:0] LAST_REG = 3'd6;

  // One decoded instruction held in the execute stage
  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  dest;
    logic [2:0]  first;
    logic [2:0]  second;
    logic [31:0] imm;
    logic [7:0]  addr;
  } instr_t;

  // Register file write-back; clear wipes every register
  typedef struct packed {
    logic        we;
    logic        clear;
    logic [2:0]  idx;
    logic [31:0] data;
  } reg_wb_t;

  // Data memory write
  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [31:0] data;
  } mem_wb_t;

  // Result of one instruction
  typedef struct packed {
    logic [1:0]  status;
    logic        active;
    logic [31:0] ip;
    logic [31:0] written;
  } exec_res_t;

endpackage

`default_nettype wire

>>> rtl/core/rme_regfile.sv
// Seven-entry register file: synchronous memory with two read ports.
// Per-entry valid bits give the all-zero reset and the clear on exit.
// Depends on rme_pkg.
`default_nettype none

module rme_regfile
  import rme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire logic [2:0]  rd_idx_a,
  input  wire logic [2:0]  rd_idx_b,
  input  wire reg_wb_t     wb,
  output logic      [31:0] rd_data_a,
  output logic      [31:0] rd_data_b
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [31:0]         q_a;
  logic [31:0]         q_b;
  logic [2:0]          idx_a;
  logic [2:0]          idx_b;

  // Write port
  always_ff @(posedge clk) begin
    if (wb.we) begin
      mem[wb.idx] <= wb.data;
    end
  end

  // Valid bits: reset and exit clear all, a write marks its entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wb.clear) begin
      valid <= '0;
    end else if (wb.we) begin
      valid[wb.idx] <= 1'b1;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a   <= mem[rd_idx_a];
      q_b   <= mem[rd_idx_b];
      idx_a <= rd_idx_a;
      idx_b <= rd_idx_b;
    end
  end

  // Entries never written since the last clear read as zero
  assign rd_data_a = (idx_a <= LAST_REG && valid[idx_a]) ? q_a : '0;
  assign rd_data_b = (idx_b <= LAST_REG && valid[idx_b]) ? q_b : '0;

endmodule

`default_nettype wire

>>> rtl/core/rme_datamem.sv
// Data memory: synchronous single-read, single-write array of words.
// Per-entry valid bits give the all-zero reset. Depends on rme_pkg.
`default_nettype none

module rme_datamem
  import rme_pkg::*;
#(
  parameter int MEM_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rd_en,
  input  wire logic [7:0]  rd_addr,
  input  wire mem_wb_t     wb,
  output logic      [31:0] rd_data
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [31:0]          mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;
  logic [31:0]          q;
  logic [AW-1:0]        idx;
  logic                 in_range;

  // Write port; callers only write addresses below the depth
  always_ff @(posedge clk) begin
    if (wb.we) begin
      mem[wb.addr[AW-1:0]] <= wb.data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wb.we) begin
      valid[wb.addr[AW-1:0]] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q        <= mem[rd_addr[AW-1:0]];
      idx      <= rd_addr[AW-1:0];
      in_range <= (9'(rd_addr) < 9'(MEM_DEPTH));
    end
  end

  assign rd_data = (in_range && valid[idx]) ? q : '0;

endmodule

`default_nettype wire

>>> rtl/core/rme_exec.sv
// Execute logic: decides status, next flag and counter, and the writes
// to register file and data memory for one instruction. Depends on rme_pkg.
`default_nettype none

module rme_exec
  import rme_pkg::*;
#(
  parameter int MEM_DEPTH = 64
) (
  input  wire instr_t      ins,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  input  wire logic [31:0] mem_data,
  input  wire logic        active,
  input  wire logic [31:0] ip,
  output exec_res_t        res,
  output reg_wb_t          rwb,
  output mem_wb_t          mwb
);

  logic [31:0] ip_inc;
  logic        d_ok;
  logic        a_ok;
  logic        b_ok;
  logic        addr_ok;

  assign ip_inc  = ip + 32'd1;
  assign d_ok    = (ins.dest <= LAST_REG);
  assign a_ok    = (ins.first <= LAST_REG);
  assign b_ok    = (ins.second <= LAST_REG);
  assign addr_ok = (9'(ins.addr) < 9'(MEM_DEPTH));

  always_comb begin
    res.status  = ST_DONE;
    res.active  = active;
    res.ip      = ip;
    res.written = '0;
    rwb         = '0;
    rwb.idx     = ins.dest;
    mwb         = '0;
    mwb.addr    = ins.addr;
    mwb.data    = op_a;
    case (ins.kind)
      KIND_START: begin
        if (!active) begin
          res.ip = ip_inc;
        end
        res.active = 1'b1;
      end
      KIND_EXIT: begin
        if (!active) begin
          res.status = ST_HALT;
        end else begin
          res.active = 1'b0;
          rwb.clear  = 1'b1;
        end
      end
      KIND_SHOW: begin
        res.ip = ip_inc;
      end
      KIND_ADD, KIND_SUB: begin
        if (!active) begin
          res.status = ST_REJECTED;
        end else if (!d_ok || !a_ok || !b_ok) begin
          res.status = ST_INVALID;
        end else begin
          res.written = (ins.kind == KIND_ADD) ? op_a + op_b : op_a - op_b;
          rwb.we      = 1'b1;
          res.ip      = ip_inc;
        end
      end
      KIND_MOVE_REG: begin
        if (!active) begin
          res.status = ST_REJECTED;
        end else if (!d_ok || !a_ok) begin
          res.status = ST_INVALID;
        end else begin
          res.written = op_a;
          rwb.we      = 1'b1;
          res.ip      = ip_inc;
        end
      end
      KIND_MOVE_IMM: begin
        if (!active) begin
          res.status = ST_REJECTED;
        end else if (!d_ok) begin
          res.status = ST_INVALID;
        end else begin
          res.written = ins.imm;
          rwb.we      = 1'b1;
          res.ip      = ip_inc;
        end
      end
      KIND_LOAD: begin
        if (!active) begin
          res.status = ST_REJECTED;
        end else if (!d_ok || !addr_ok) begin
          res.status = ST_INVALID;
        end else begin
          res.written = mem_data;
          rwb.we      = 1'b1;
          res.ip      = ip_inc;
        end
      end
      KIND_STORE: begin
        if (!active) begin
          res.status = ST_REJECTED;
        end else if (!d_ok || !addr_ok) begin
          res.status = ST_INVALID;
        end else begin
          mwb.we = 1'b1;
          res.ip = ip_inc;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    rwb.data = res.written;
  end

endmodule

`default_nettype wire

>>> rtl/core/register_machine_execute_unit.sv
// Top level of the register machine execute unit: read stage, execute
// stage with forwarding, output register. Depends on rme_pkg, rme_regfile,
// rme_datamem and rme_exec.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | in_valid / in_ready  | kind dest_index first_index
//            |                      | second_index immediate address
//   output   | out_valid/out_ready  | status active ip written_value
//
// One instruction per cycle sustained while the output is not stalled.
// The register file and data memory are read as an instruction is accepted;
// execute and write-back finish when it moves into the output register.
// The write of the instruction leaving execute is forwarded to the one
// entering it, so back-to-back dependent instructions never stall.
// Reset clears flag, counter and valid bits at once; no clearing pass.
// A stalled output holds the execute stage; input stalls only then.
`default_nettype none

module register_machine_execute_unit
  import rme_pkg::*;
#(
  parameter int MEM_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [3:0]  kind,
  input  wire logic        [2:0]  dest_index,
  input  wire logic        [2:0]  first_index,
  input  wire logic        [2:0]  second_index,
  input  wire logic signed [31:0] immediate,
  input  wire logic        [7:0]  address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [1:0]  status,
  output logic                    active,
  output logic             [31:0] ip,
  output logic signed      [31:0] written_value
);

  logic        accept;
  logic        ex_valid;
  logic        ex_adv;
  instr_t      ex_ins;
  logic        act_flag;
  logic [31:0] icount;
  logic [2:0]  rd_idx_a;
  logic [2:0]  ex_idx_a;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] dm_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] mem_data;
  exec_res_t   res;
  reg_wb_t     rwb;
  mem_wb_t     mwb;
  reg_wb_t     rwb_g;
  mem_wb_t     mwb_g;
  reg_wb_t     fw_reg;
  mem_wb_t     fw_mem;

  // Handshake
  assign ex_adv   = ex_valid && (!out_valid || out_ready);
  assign in_ready = !ex_valid || ex_adv;
  assign accept   = in_valid && in_ready;

  // Store reads its data register through port A
  assign rd_idx_a = (kind == KIND_STORE) ? dest_index : first_index;
  assign ex_idx_a = (ex_ins.kind == KIND_STORE) ? ex_ins.dest : ex_ins.first;

  // Execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (ex_adv) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_ins.kind   <= kind;
      ex_ins.dest   <= dest_index;
      ex_ins.first  <= first_index;
      ex_ins.second <= second_index;
      ex_ins.imm    <= immediate;
      ex_ins.addr   <= address;
    end
  end

  // Gate writes to the cycle the instruction retires
  always_comb begin
    rwb_g       = rwb;
    rwb_g.we    = rwb.we && ex_adv;
    rwb_g.clear = rwb.clear && ex_adv;
    mwb_g       = mwb;
    mwb_g.we    = mwb.we && ex_adv;
  end

  rme_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_idx_a  (rd_idx_a),
    .rd_idx_b  (second_index),
    .wb        (rwb_g),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  rme_datamem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_datamem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (address),
    .wb      (mwb_g),
    .rd_data (dm_q)
  );

  // Hold the last retired writes; they may have landed with our read
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_reg.we    <= 1'b0;
      fw_reg.clear <= 1'b0;
      fw_mem.we    <= 1'b0;
    end else if (ex_adv) begin
      fw_reg.we    <= rwb.we;
      fw_reg.clear <= rwb.clear;
      fw_mem.we    <= mwb.we;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      fw_reg.idx  <= rwb.idx;
      fw_reg.data <= rwb.data;
      fw_mem.addr <= mwb.addr;
      fw_mem.data <= mwb.data;
    end
  end

  // Forward over stale read data; a retired clear reads as zero
  assign op_a     = fw_reg.clear ? '0 :
                    (fw_reg.we && fw_reg.idx == ex_idx_a) ? fw_reg.data : rf_a;
  assign op_b     = fw_reg.clear ? '0 :
                    (fw_reg.we && fw_reg.idx == ex_ins.second) ? fw_reg.data : rf_b;
  assign mem_data = (fw_mem.we && fw_mem.addr == ex_ins.addr) ? fw_mem.data : dm_q;

  rme_exec #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_exec (
    .ins      (ex_ins),
    .op_a     (op_a),
    .op_b     (op_b),
    .mem_data (mem_data),
    .active   (act_flag),
    .ip       (icount),
    .res      (res),
    .rwb      (rwb),
    .mwb      (mwb)
  );

  // Machine flag and instruction counter
  always_ff @(posedge clk) begin
    if (rst) begin
      act_flag <= 1'b0;
      icount   <= '0;
    end else if (ex_adv) begin
      act_flag <= res.active;
      icount   <= res.ip;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      status        <= res.status;
      active        <= res.active;
      ip            <= res.ip;
      written_value <= res.written;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rme_checker.sv
// Port-level checker for the register machine execute unit, bound to the
// top level. Depends on rme_pkg and register_machine_execute_unit.
`default_nettype none

module rme_checker
  import rme_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic        [1:0]  status,
  input wire logic               active,
  input wire logic        [31:0] ip,
  input wire logic signed [31:0] written_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(ip)
      && $stable(active) && $stable(written_value))
    else $error("stalled result changed");

  // Input only stalls behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the output free");

  // Results other than done write no register
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> written_value == 32'sd0)
    else $error("failed instruction reports a written value");

  // Halt and rejection only come from an inactive machine
  a_inactive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_HALT || status == ST_REJECTED) |-> !active)
    else $error("halt or rejection while active");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind register_machine_execute_unit rme_checker u_rme_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .active        (active),
  .ip            (ip),
  .written_value (written_value)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for register_machine_execute_unit: directed and random
// instruction streams with random idle on both channels, checked against an
// in-bench machine model. Depends on rme_pkg and the RTL of the unit.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  localparam int MEM_DEPTH    = 64;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SHOW_ERRORS  = 10;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic        [3:0]  kind          = '0;
  logic        [2:0]  dest_index    = '0;
  logic        [2:0]  first_index   = '0;
  logic        [2:0]  second_index  = '0;
  logic signed [31:0] immediate     = '0;
  logic        [7:0]  address       = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic        [1:0]  status;
  logic               active;
  logic        [31:0] ip;
  logic signed [31:0] written_value;

  // Machine state as the bench expects it
  bit [31:0] arch_regs [NUM_REGS];
  bit [31:0] arch_mem  [MEM_DEPTH];
  bit [31:0] arch_ip;
  bit        arch_active;

  exec_res_t pending_results[$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  status_count [4];
  int  idle_cycles  = 0;
  int  sink_hold    = 0;
  bit  src_steady   = 1'b0;
  bit  sink_steady  = 1'b0;

  register_machine_execute_unit #(
    .MEM_DEPTH(MEM_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .dest_index   (dest_index),
    .first_index  (first_index),
    .second_index (second_index),
    .immediate    (immediate),
    .address      (address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .active       (active),
    .ip           (ip),
    .written_value(written_value)
  );

  always #4 clk = ~clk;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_ERRORS) $display("ERROR: %s", msg);
  endfunction

  // Execute one instruction on the bench state and return its result
  function automatic exec_res_t run_instr(input instr_t ins);
    exec_res_t res;
    bit        bad_operand;
    bit [31:0] value;
    res = '0;
    res.status = ST_DONE;
    value = '0;
    bad_operand = ins.dest > LAST_REG;
    if (ins.kind == KIND_ADD || ins.kind == KIND_SUB)
      bad_operand |= ins.first > LAST_REG || ins.second > LAST_REG;
    if (ins.kind == KIND_MOVE_REG) bad_operand |= ins.first > LAST_REG;
    if (ins.kind == KIND_LOAD || ins.kind == KIND_STORE) bad_operand |= ins.addr >= MEM_DEPTH;
    case (ins.kind)
      KIND_START: begin
        if (!arch_active) arch_ip++;
        arch_active = 1'b1;
      end
      KIND_EXIT: begin
        if (!arch_active) begin
          res.status = ST_HALT;
        end else begin
          arch_active = 1'b0;
          foreach (arch_regs[i]) arch_regs[i] = '0;
        end
      end
      KIND_SHOW: arch_ip++;
      KIND_ADD, KIND_SUB, KIND_MOVE_REG, KIND_MOVE_IMM, KIND_LOAD, KIND_STORE: begin
        if (!arch_active) begin
          res.status = ST_REJECTED;
        end else if (bad_operand) begin
          res.status = ST_INVALID;
        end else begin
          case (ins.kind)
            KIND_ADD:      value = arch_regs[ins.first] + arch_regs[ins.second];
            KIND_SUB:      value = arch_regs[ins.first] - arch_regs[ins.second];
            KIND_MOVE_REG: value = arch_regs[ins.first];
            KIND_MOVE_IMM: value = ins.imm;
            KIND_LOAD:     value = arch_mem[ins.addr];
            default:       value = '0;
          endcase
          // Store writes memory only; everything else writes back a register
          if (ins.kind == KIND_STORE) begin
            arch_mem[ins.addr] = arch_regs[ins.dest];
          end else begin
            arch_regs[ins.dest] = value;
            res.written = value;
          end
          arch_ip++;
        end
      end
      default: res.status = ST_INVALID;
    endcase
    res.active = arch_active;
    res.ip = arch_ip;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [2:0] pick_reg();
    if ($urandom_range(0, 15) == 0) return 3'd7;
    return 3'($urandom_range(0, LAST_REG));
  endfunction

  function automatic instr_t make_instr(input logic [3:0] k, input logic [2:0] d,
                                        input logic [2:0] a, input logic [2:0] b,
                                        input logic [31:0] imm, input logic [7:0] addr);
    instr_t ins;
    ins.kind   = k;
    ins.dest   = d;
    ins.first  = a;
    ins.second = b;
    ins.imm    = imm;
    ins.addr   = addr;
    return ins;
  endfunction

  // Well-formed mix of operations, or raw noise over every field
  function automatic instr_t random_instr(input bit noise);
    instr_t ins;
    int     r;
    case ($urandom_range(0, 9))
      0:       ins.imm = 32'h8000_0000;
      1:       ins.imm = 32'h7fff_ffff;
      2:       ins.imm = '1;
      3:       ins.imm = '0;
      default: ins.imm = $urandom;
    endcase
    if (noise) begin
      ins.kind   = 4'($urandom_range(0, 15));
      ins.dest   = 3'($urandom_range(0, 7));
      ins.first  = 3'($urandom_range(0, 7));
      ins.second = 3'($urandom_range(0, 7));
      ins.addr   = 8'($urandom_range(0, 255));
      return ins;
    end
    r = $urandom_range(0, 99);
    if (r < 2)       ins.kind = KIND_START;
    else if (r < 4)  ins.kind = KIND_EXIT;
    else if (r < 6)  ins.kind = 4'($urandom_range(9, 15));
    else if (r < 18) ins.kind = KIND_ADD;
    else if (r < 28) ins.kind = KIND_SUB;
    else if (r < 32) ins.kind = KIND_SHOW;
    else if (r < 42) ins.kind = KIND_MOVE_REG;
    else if (r < 58) ins.kind = KIND_MOVE_IMM;
    else if (r < 78) ins.kind = KIND_LOAD;
    else             ins.kind = KIND_STORE;
    ins.dest   = pick_reg();
    ins.first  = pick_reg();
    ins.second = pick_reg();
    // Send close to half of the addresses to the first eight words so loads see earlier stores
    r = $urandom_range(0, 99);
    if (r < 10)      ins.addr = 8'($urandom_range(0, 255));
    else if (r < 55) ins.addr = 8'($urandom_range(0, 7));
    else             ins.addr = 8'($urandom_range(0, MEM_DEPTH - 1));
    return ins;
  endfunction

  // Offer one instruction and record its expected result once accepted
  task automatic send_instr(input instr_t ins);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= ins.kind;
    dest_index   <= ins.dest;
    first_index  <= ins.first;
    second_index <= ins.second;
    immediate    <= ins.imm;
    address      <= ins.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(run_instr(ins));
    items_sent++;
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_instr(make_instr(KIND_EXIT,     0, 0, 0, '0, 0));  // halt while inactive
    send_instr(make_instr(KIND_ADD,      1, 2, 3, '0, 0));  // rejected while inactive
    send_instr(make_instr(KIND_STORE,    0, 0, 0, '0, 5));
    send_instr(make_instr(4'd15,         7, 7, 7, '1, 255));  // unused kind
    send_instr(make_instr(KIND_SHOW,     0, 0, 0, '0, 0));
    send_instr(make_instr(KIND_START,    0, 0, 0, '0, 0));
    send_instr(make_instr(KIND_START,    0, 0, 0, '0, 0));  // already active, ip holds
    send_instr(make_instr(KIND_MOVE_IMM, 0, 0, 0, 32'h7fff_ffff, 0));
    send_instr(make_instr(KIND_MOVE_IMM, 1, 0, 0, 32'h8000_0000, 0));
    send_instr(make_instr(KIND_MOVE_IMM, 2, 0, 0, 32'hffff_ffff, 0));
    send_instr(make_instr(KIND_MOVE_IMM, 6, 0, 0, 32'h0000_0001, 0));
    send_instr(make_instr(KIND_ADD,      3, 0, 6, '0, 0));  // signed overflow wraps
    send_instr(make_instr(KIND_SUB,      4, 1, 6, '0, 0));  // signed underflow wraps
    send_instr(make_instr(KIND_MOVE_REG, 5, 3, 0, '0, 0));  // back-to-back dependency
    send_instr(make_instr(KIND_ADD,      5, 5, 2, '0, 0));
    send_instr(make_instr(KIND_MOVE_REG, 7, 0, 0, '0, 0));  // bad destination
    send_instr(make_instr(KIND_ADD,      0, 7, 1, '0, 0));  // bad first source
    send_instr(make_instr(KIND_SUB,      0, 1, 7, '0, 0));  // bad second source
    send_instr(make_instr(KIND_MOVE_IMM, 7, 0, 0, '1, 0));
    send_instr(make_instr(KIND_STORE,    2, 0, 0, '0, 8'(MEM_DEPTH - 1)));
    send_instr(make_instr(KIND_STORE,    0, 0, 0, '0, 8'(MEM_DEPTH)));  // just past the end
    send_instr(make_instr(KIND_LOAD,     6, 0, 0, '0, 8'(MEM_DEPTH - 1)));
    send_instr(make_instr(KIND_LOAD,     0, 0, 0, '0, 255));
    send_instr(make_instr(KIND_LOAD,     3, 0, 0, '0, 0));  // never written, reads zero
    send_instr(make_instr(4'd9,          0, 0, 0, '0, 0));
    send_instr(make_instr(KIND_EXIT,     0, 0, 0, '0, 0));  // clears registers
    send_instr(make_instr(KIND_START,    0, 0, 0, '0, 0));
    send_instr(make_instr(KIND_ADD,      0, 1, 2, '0, 0));  // sources now zero
    send_instr(make_instr(KIND_LOAD,     1, 0, 0, '0, 8'(MEM_DEPTH - 1)));  // memory kept
  endtask

  // Short programs: start, a run of operations, then an exit in about half of them
  task automatic test_random_programs();
    repeat (8) begin
      send_instr(make_instr(KIND_START, 0, 0, 0, '0, 0));
      repeat ($urandom_range(40, 70)) send_instr(random_instr(1'b0));
      if ($urandom_range(0, 1) != 0) send_instr(make_instr(KIND_EXIT, 0, 0, 0, '0, 0));
    end
  endtask

  // Hold the output off while the sender keeps pushing
  task automatic test_backpressure();
    send_instr(make_instr(KIND_START, 0, 0, 0, '0, 0));
    src_steady = 1'b1;
    sink_hold = 60;
    repeat (30) send_instr(random_instr(1'b0));
    src_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (12) send_instr(random_instr(1'b0));
      wait_drained();
    end
  endtask

  task automatic test_steady_flow();
    src_steady = 1'b1;
    sink_steady = 1'b1;
    repeat (100) send_instr(random_instr(1'b0));
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_noise();
    repeat (100) send_instr(random_instr(1'b1));
  endtask

  // Receiver pacing: ready runs, random stalls, and requested long holds
  initial begin : sink_pacing
    int span;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        span = sink_hold;
        sink_hold = 0;
        out_ready <= 1'b0;
        repeat (span - 1) @(posedge clk);
      end else if (sink_steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        if (!sink_steady) repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    exec_res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_count[status]++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d active %0d ip %0h written %0h",
                               status, active, ip, written_value));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || active !== want.active || ip !== want.ip ||
            written_value !== want.written)
          note_failure($sformatf({"result %0d: expected status %0d active %0d ip %0h ",
                                  "written %0h, got status %0d active %0d ip %0h written %0h"},
                                 results_seen, want.status, want.active, want.ip,
                                 want.written, status, active, ip, written_value));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("register_machine_execute_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_programs();
    test_backpressure();
    test_drain_pause();
    test_steady_flow();
    test_noise();
    // Drain, then keep the output open a little longer for strays
    wait_drained();
    sink_steady = 1'b1;
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d instructions and %0d results under random idle and long stalls",
             items_sent, results_seen);
    $display("statuses seen: done %0d, invalid %0d, rejected %0d, halt %0d; %0d mismatches",
             status_count[ST_DONE], status_count[ST_INVALID], status_count[ST_REJECTED],
             status_count[ST_HALT], fail_count);
    if (fail_count == 0) begin
      $display("register_machine_execute_unit regression: pass");
    end else begin
      $display("register_machine_execute_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> register_machine_execute_unit.f
rtl/core/rme_pkg.sv
rtl/core/rme_regfile.sv
rtl/core/rme_datamem.sv
rtl/core/rme_exec.sv
rtl/core/register_machine_execute_unit.sv
rtl/core/rme_checker.sv
test/tb_top.sv
